FILE: rtl/core/kli_pkg.sv
// Shared types and constants of the keyframe linear interpolator.
// Depends on nothing; kli_ctrl, kli_dp and the top level in rtl/core import it.
`default_nettype none

package kli_pkg;

	localparam int MAX_KEYFRAMES = 16;
	localparam int CHANNELS      = 5;
	localparam int CH_W          = 32;
	localparam int KEY_W         = CHANNELS * CH_W;
	localparam int SLOT_W        = $clog2(MAX_KEYFRAMES);
	localparam int FRAMES_W      = 5;
	localparam int STEPS_W       = 16;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 16;

	// Restoring division: one quotient bit of the 33-bit magnitude per cycle.
	localparam int DIV_STEPS     = CH_W + 1;
	localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

	localparam logic [STEPS_W-1:0]  STEPS_RESET  = 16'd600;
	localparam logic [FRAMES_W-1:0] FRAMES_RESET = 5'd0;

	// Item modes.
	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_WRITE  = 2'd1;
	localparam logic [1:0] MODE_TOGGLE = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS  = 1'd1;

	typedef struct packed {
		logic [1:0]        mode;
		logic [SLOT_W-1:0] frame_slot;
		logic signed [31:0] key_x;
		logic signed [31:0] key_y;
		logic signed [31:0] key_z;
		logic signed [31:0] key_yaw;
		logic signed [31:0] key_roll;
	} kli_item_t;

	typedef struct packed {
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [31:0] pose_z;
		logic signed [31:0] pose_yaw;
		logic signed [31:0] pose_roll;
		logic               playing;
		logic [3:0]         segment;
		logic               finished;
	} kli_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_RD_CUR,
		ST_RD_NXT,
		ST_LOAD,
		ST_DIVIDE,
		ST_FIX,
		ST_DONE
	} kli_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic do_start;
		logic do_stop;
		logic do_end;
		logic do_advance;
		logic do_step;
		logic ram_write;
		logic rd_nxt;
		logic load_cur;
		logic load_pose;
		logic load_div;
		logic div_run;
		logic fix_inc;
		logic publish;
	} kli_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic playing;
		logic can_start;
		logic at_boundary;
		logic last_segment;
		logic res_free;
	} kli_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/kli_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the keyframe table.
`default_nettype none

module kli_ram #(
	parameter int WIDTH = 160,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/core/kli_ctrl.sv
// Controller of the keyframe interpolator: decodes each word and sequences
// table writes and reads, the division of all five lanes and the result hand-off. Uses kli_pkg.
`default_nettype none

module kli_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output      logic               cmd_ready,
	input  wire logic [1:0]         mode,
	input  wire kli_pkg::kli_stat_t stat,
	output      kli_pkg::kli_cmd_t  ctl
);
	import kli_pkg::*;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_WRITE,
		OP_START,
		OP_STOP,
		OP_END,
		OP_ADVANCE,
		OP_STEP
	} kli_op_t;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	kli_state_t           state_q, state_nx;
	kli_op_t              op;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 load_pose_q;
	logic                 accept;

	assign cmd_ready = (state_q == ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;

	// What the incoming word does, given the present play state.
	always_comb begin
		op = OP_NONE;
		case (mode)
			MODE_WRITE: op = OP_WRITE;
			MODE_TOGGLE: op = stat.can_start ? OP_START : OP_STOP;
			MODE_TICK: begin
				if (stat.playing) begin
					if (!stat.at_boundary) begin
						op = OP_STEP;
					end else if (stat.last_segment) begin
						op = OP_END;
					end else begin
						op = OP_ADVANCE;
					end
				end
			end
			default: op = OP_NONE;
		endcase
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op)
						OP_WRITE: state_nx = ST_WRITE;
						OP_START, OP_ADVANCE: state_nx = ST_RD_CUR;
						default: state_nx = ST_DONE;
					endcase
				end
			end
			ST_WRITE:  state_nx = ST_DONE;
			ST_RD_CUR: state_nx = ST_RD_NXT;
			ST_RD_NXT: state_nx = ST_LOAD;
			ST_LOAD:   state_nx = ST_DIVIDE;
			ST_DIVIDE: state_nx = (cnt_q == DIV_LAST) ? ST_FIX : ST_DIVIDE;
			ST_FIX:    state_nx = ST_DONE;
			ST_DONE:   state_nx = stat.res_free ? ST_IDLE : ST_DONE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.accept     = accept;
				ctl.do_start   = accept && (op == OP_START);
				ctl.do_stop    = accept && (op == OP_STOP);
				ctl.do_end     = accept && (op == OP_END);
				ctl.do_advance = accept && (op == OP_ADVANCE);
				ctl.do_step    = accept && (op == OP_STEP);
			end
			ST_WRITE: ctl.ram_write = 1'b1;
			ST_RD_CUR: ctl.rd_nxt = 1'b0;
			ST_RD_NXT: begin
				ctl.rd_nxt    = 1'b1;
				ctl.load_cur  = 1'b1;
				ctl.load_pose = load_pose_q;
			end
			ST_LOAD:   ctl.load_div = 1'b1;
			ST_DIVIDE: ctl.div_run = 1'b1;
			ST_FIX:    ctl.fix_inc = 1'b1;
			ST_DONE:   ctl.publish = stat.res_free;
			default:   ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			load_pose_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_DIVIDE) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (ctl.do_start) begin
				load_pose_q <= 1'b1;
			end else if (ctl.do_advance) begin
				load_pose_q <= 1'b0;
			end
		end
	end

	a_div_enter: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |=> (state_q == ST_DIVIDE && cnt_q == '0))
		else $error("division did not start from a cleared count");

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE && cnt_q != DIV_LAST) |=> state_q == ST_DIVIDE)
		else $error("division left before its last quotient bit");

	a_word_taken: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted word was not processed");

endmodule

`default_nettype wire

FILE: rtl/core/kli_dp.sv
// Datapath of the keyframe interpolator: configuration, pose, increments,
// five division lanes, play state and the result register. Uses kli_pkg.
`default_nettype none

module kli_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire kli_pkg::kli_item_t                item,
	input  wire kli_pkg::kli_cmd_t                 ctl,
	output      kli_pkg::kli_stat_t                stat,
	input  wire logic                              cfg_we,
	input  wire logic [kli_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [kli_pkg::CFG_DATA_W-1:0]    cfg_data,
	output      logic                              ram_we,
	output      logic [kli_pkg::SLOT_W-1:0]        ram_waddr,
	output      logic [kli_pkg::KEY_W-1:0]         ram_wdata,
	output      logic [kli_pkg::SLOT_W-1:0]        ram_raddr,
	input  wire logic [kli_pkg::KEY_W-1:0]         ram_rdata,
	output      logic                              res_valid,
	input  wire logic                              res_ready,
	output      kli_pkg::kli_result_t              res
);
	import kli_pkg::*;

	localparam logic signed [CH_W-1:0] S32_MAX = {1'b0, {(CH_W-1){1'b1}}};
	localparam logic signed [CH_W-1:0] S32_MIN = {1'b1, {(CH_W-1){1'b0}}};

	logic [FRAMES_W-1:0] frames_q;
	logic [STEPS_W-1:0]  steps_q;
	logic [FRAMES_W-1:0] frames_eff;
	logic [STEPS_W-1:0]  steps_eff;

	logic                play_q;
	logic                fin_q;
	logic [3:0]          seg_q;
	logic [STEPS_W-1:0]  step_q;

	logic signed [CH_W-1:0] pose_q [CHANNELS];
	logic signed [CH_W-1:0] inc_q  [CHANNELS];
	logic signed [CH_W-1:0] cur_s1 [CHANNELS];
	logic [CH_W:0]          dvd_q  [CHANNELS];
	logic [STEPS_W-1:0]     rem_q  [CHANNELS];
	logic                   neg_q  [CHANNELS];

	logic signed [CH_W-1:0] pose_sum [CHANNELS];
	logic [CH_W:0]          mag_nx   [CHANNELS];
	logic                   neg_nx   [CHANNELS];
	logic [STEPS_W-1:0]     rem_nx   [CHANNELS];
	logic                   qbit     [CHANNELS];
	logic signed [CH_W-1:0] inc_nx   [CHANNELS];

	kli_item_t   item_q;
	kli_result_t res_q;
	logic        res_valid_q;

	function automatic logic signed [CH_W-1:0] sat_add(input logic signed [CH_W-1:0] a,
		input logic signed [CH_W-1:0] b);
		logic [CH_W:0] s;
		s = {a[CH_W-1], a} + {b[CH_W-1], b};
		if (s[CH_W] != s[CH_W-1]) begin
			return s[CH_W] ? S32_MIN : S32_MAX;
		end
		return s[CH_W-1:0];
	endfunction

	// Signed quotient from sign and 33-bit magnitude, clamped to 32 bits.
	function automatic logic signed [CH_W-1:0] sat_quot(input logic neg,
		input logic [CH_W:0] mag);
		logic [CH_W:0] neg_lim;
		neg_lim = {2'b01, {(CH_W-1){1'b0}}};
		if (neg) begin
			if (mag > neg_lim) begin
				return S32_MIN;
			end
			return CH_W'(~mag[CH_W-1:0] + 1'b1);
		end
		if (mag > {2'b00, {(CH_W-1){1'b1}}}) begin
			return S32_MAX;
		end
		return mag[CH_W-1:0];
	endfunction

	assign frames_eff = (frames_q > FRAMES_W'(MAX_KEYFRAMES)) ? FRAMES_W'(MAX_KEYFRAMES)
		: frames_q;
	assign steps_eff  = (steps_q == '0) ? STEPS_W'(1) : steps_q;

	assign stat.playing      = play_q;
	assign stat.can_start    = !play_q && (frames_eff > FRAMES_W'(1));
	assign stat.at_boundary  = (step_q >= steps_eff);
	assign stat.last_segment = ({2'b00, seg_q} + 6'd3) > {1'b0, frames_eff};
	assign stat.res_free     = !res_valid_q || res_ready;

	assign ram_we    = ctl.ram_write && ({1'b0, item_q.frame_slot} < (SLOT_W+1)'(MAX_KEYFRAMES));
	assign ram_waddr = item_q.frame_slot;
	assign ram_wdata = {item_q.key_roll, item_q.key_yaw, item_q.key_z, item_q.key_y,
		item_q.key_x};
	assign ram_raddr = ctl.rd_nxt ? SLOT_W'(seg_q + 1'b1) : SLOT_W'(seg_q);

	// Per-lane arithmetic: pose step, difference load, one division bit, finish.
	always_comb begin
		logic [CH_W:0]      diff;
		logic [STEPS_W:0]   trial;
		logic [STEPS_W:0]   sub;
		logic signed [CH_W-1:0] nk;
		for (int c = 0; c < CHANNELS; c++) begin
			pose_sum[c] = sat_add(pose_q[c], inc_q[c]);
			nk          = ram_rdata[c*CH_W +: CH_W];
			diff        = {nk[CH_W-1], nk} - {cur_s1[c][CH_W-1], cur_s1[c]};
			neg_nx[c]   = diff[CH_W];
			mag_nx[c]   = diff[CH_W] ? (~diff + 1'b1) : diff;
			trial       = {rem_q[c], dvd_q[c][CH_W]};
			sub         = trial - {1'b0, steps_eff};
			qbit[c]     = (trial >= {1'b0, steps_eff});
			rem_nx[c]   = qbit[c] ? sub[STEPS_W-1:0] : trial[STEPS_W-1:0];
			inc_nx[c]   = sat_quot(neg_q[c], dvd_q[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
			steps_q  <= STEPS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAMES: frames_q <= cfg_data[FRAMES_W-1:0];
				REG_STEPS:  steps_q  <= cfg_data[STEPS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_q <= 1'b0;
			fin_q  <= 1'b0;
			seg_q  <= '0;
			step_q <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				pose_q[c] <= '0;
				inc_q[c]  <= '0;
			end
		end else begin
			if (ctl.accept) begin
				fin_q <= ctl.do_end;
			end
			if (ctl.do_start) begin
				play_q <= 1'b1;
				seg_q  <= '0;
				step_q <= '0;
			end
			if (ctl.do_stop) begin
				play_q <= 1'b0;
			end
			if (ctl.do_end) begin
				play_q <= 1'b0;
				seg_q  <= '0;
			end
			if (ctl.do_advance) begin
				seg_q  <= seg_q + 1'b1;
				step_q <= '0;
			end
			if (ctl.do_step) begin
				step_q <= step_q + 1'b1;
			end
			for (int c = 0; c < CHANNELS; c++) begin
				if (ctl.do_step) begin
					pose_q[c] <= pose_sum[c];
				end else if (ctl.load_pose) begin
					pose_q[c] <= ram_rdata[c*CH_W +: CH_W];
				end
				if (ctl.fix_inc) begin
					inc_q[c] <= inc_nx[c];
				end
			end
		end
	end

	// Division lanes, captured word and result payload; no reset needed.
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			item_q <= item;
		end
		for (int c = 0; c < CHANNELS; c++) begin
			if (ctl.load_cur) begin
				cur_s1[c] <= ram_rdata[c*CH_W +: CH_W];
			end
			if (ctl.load_div) begin
				dvd_q[c] <= mag_nx[c];
				neg_q[c] <= neg_nx[c];
				rem_q[c] <= '0;
			end else if (ctl.div_run) begin
				dvd_q[c] <= {dvd_q[c][CH_W-1:0], qbit[c]};
				rem_q[c] <= rem_nx[c];
			end
		end
		if (ctl.publish) begin
			res_q.pose_x    <= pose_q[0];
			res_q.pose_y    <= pose_q[1];
			res_q.pose_z    <= pose_q[2];
			res_q.pose_yaw  <= pose_q[3];
			res_q.pose_roll <= pose_q[4];
			res_q.playing   <= play_q;
			res_q.segment   <= seg_q;
			res_q.finished  <= fin_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.publish) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.publish |-> (!res_valid_q || res_ready))
		else $error("result register overwritten before it was taken");

	a_fin_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.finished) |-> !res_q.playing)
		else $error("finished reported while still playing");

endmodule

`default_nettype wire

FILE: rtl/core/keyframe_linear_interpolator.sv
// Top level of the keyframe linear interpolator: joins controller, datapath
// and keyframe RAM. Depends on kli_pkg, kli_ram, kli_ctrl and kli_dp.
//
//   channel  handshake              payload           direction
//   cmd      cmd_valid / cmd_ready  kli_item_t        into the block
//   res      res_valid / res_ready  kli_result_t      out of the block
//   cfg      cfg_we                 cfg_index, cfg_data  into the block
//
// Every accepted word yields exactly one result word. A write word goes
// through a table write; a tick or toggle that needs no new increments goes
// straight to the result; a start or a segment advance runs two reads of
// the table RAM's one read port, the restoring divider (one quotient bit
// per cycle, five channel lanes side by side) and a step to sign and clamp.
// Reset clears the play state, pose, increments and registers; the keyframe
// table is not cleared and must be written before play.
// The next word is accepted while a result still waits in the output
// register; the block only stalls at the hand-off if that register is full.
`default_nettype none

module keyframe_linear_interpolator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cmd_valid,
	output      logic                           cmd_ready,
	input  wire kli_pkg::kli_item_t             cmd,
	output      logic                           res_valid,
	input  wire logic                           res_ready,
	output      kli_pkg::kli_result_t           res,
	input  wire logic                           cfg_we,
	input  wire logic [kli_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [kli_pkg::CFG_DATA_W-1:0] cfg_data
);
	import kli_pkg::*;

	kli_cmd_t            ctl;
	kli_stat_t           stat;
	logic                ram_we;
	logic [SLOT_W-1:0]   ram_waddr;
	logic [KEY_W-1:0]    ram_wdata;
	logic [SLOT_W-1:0]   ram_raddr;
	logic [KEY_W-1:0]    ram_rdata;

	// The controller only needs the mode of the incoming word; the datapath
	// captures the whole word when it is accepted.
	kli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.mode      (cmd.mode),
		.stat      (stat),
		.ctl       (ctl)
	);

	kli_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (cmd),
		.ctl       (ctl),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Keyframe table: one 160-bit row of five channels per slot.
	kli_ram #(
		.WIDTH (KEY_W),
		.DEPTH (MAX_KEYFRAMES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking bench for keyframe_linear_interpolator: directed and random command words,
// checked against a built-in pose predictor. Needs kli_pkg and the RTL of the block.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import kli_pkg::*;

	// The fourth mode code has no meaning in the block; it must just report the state.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 200;
	localparam int RANDOM_WORDS = 500;
	localparam int PRINT_LIMIT  = 40;

	localparam logic signed [CH_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [CH_W-1:0] Q_MIN = 32'sh8000_0000;

	// Predicts the result word of every accepted command word and keeps the predictions in
	// order until the block hands the matching result out.
	class pose_predictor;
		logic signed [CH_W-1:0] keys [MAX_KEYFRAMES][CHANNELS];
		logic signed [CH_W-1:0] step_inc [CHANNELS];
		logic signed [CH_W-1:0] pose [CHANNELS];
		bit                     running;
		int unsigned            seg_idx;
		int unsigned            step_cnt;
		logic [FRAMES_W-1:0]    frames;
		logic [STEPS_W-1:0]     steps;
		kli_result_t            pending_poses[$];
		int                     mismatches;
		int                     results_seen;

		function new();
			foreach (keys[s, c]) keys[s][c] = '0;
			foreach (pose[c]) begin
				pose[c] = '0;
				step_inc[c] = '0;
			end
			running = 1'b0;
			seg_idx = 0;
			step_cnt = 0;
			frames = FRAMES_RESET;
			steps = STEPS_RESET;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function int unsigned frames_used();
			return (frames > MAX_KEYFRAMES) ? MAX_KEYFRAMES : frames;
		endfunction

		function int unsigned steps_used();
			return (steps == 0) ? 1 : steps;
		endfunction

		function logic signed [CH_W-1:0] clamp32(longint v);
			if (v > longint'(Q_MAX))
				return Q_MAX;
			if (v < longint'(Q_MIN))
				return Q_MIN;
			return v[CH_W-1:0];
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_FRAMES)
				frames = val[FRAMES_W-1:0];
			else
				steps = val[STEPS_W-1:0];
		endfunction

		// Increments of the current segment; past the last frame in use they are kept.
		function void load_increments();
			int unsigned nxt;
			longint      diff;
			nxt = seg_idx + 1;
			if (nxt >= frames_used() || nxt >= MAX_KEYFRAMES)
				return;
			for (int c = 0; c < CHANNELS; c++) begin
				diff = longint'(keys[nxt][c]) - longint'(keys[seg_idx][c]);
				step_inc[c] = clamp32(diff / longint'(steps_used()));
			end
		endfunction

		function void note_word(kli_item_t w);
			kli_result_t e;
			bit          fin;
			fin = 1'b0;
			case (w.mode)
				MODE_WRITE: begin
					keys[w.frame_slot][0] = w.key_x;
					keys[w.frame_slot][1] = w.key_y;
					keys[w.frame_slot][2] = w.key_z;
					keys[w.frame_slot][3] = w.key_yaw;
					keys[w.frame_slot][4] = w.key_roll;
				end
				MODE_TOGGLE: begin
					if (!running && frames_used() > 1) begin
						for (int c = 0; c < CHANNELS; c++)
							pose[c] = keys[0][c];
						seg_idx = 0;
						step_cnt = 0;
						load_increments();
						running = 1'b1;
					end else begin
						running = 1'b0;
					end
				end
				MODE_TICK: begin
					if (running) begin
						if (step_cnt >= steps_used()) begin
							seg_idx++;
							if (seg_idx + 2 > frames_used()) begin
								seg_idx = 0;
								running = 1'b0;
								fin = 1'b1;
							end else begin
								step_cnt = 0;
								load_increments();
							end
						end else begin
							for (int c = 0; c < CHANNELS; c++)
								pose[c] = clamp32(longint'(pose[c]) + longint'(step_inc[c]));
							step_cnt = (step_cnt + 1) & 32'hFFFF;
						end
					end
				end
				default: ;
			endcase
			e.pose_x = pose[0];
			e.pose_y = pose[1];
			e.pose_z = pose[2];
			e.pose_yaw = pose[3];
			e.pose_roll = pose[4];
			e.playing = running;
			e.segment = seg_idx[3:0];
			e.finished = fin;
			pending_poses.push_back(e);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			if (mismatches < PRINT_LIMIT)
				$display("MISMATCH result %0d %s: got %h, expected %h",
					results_seen, what, got, want);
			mismatches++;
		endtask

		task check_result(kli_result_t r);
			kli_result_t e;
			results_seen++;
			if (pending_poses.size() == 0) begin
				report("arrived with nothing pending", r.pose_x, '0);
				return;
			end
			e = pending_poses.pop_front();
			if (r.pose_x !== e.pose_x)
				report("pose_x", r.pose_x, e.pose_x);
			if (r.pose_y !== e.pose_y)
				report("pose_y", r.pose_y, e.pose_y);
			if (r.pose_z !== e.pose_z)
				report("pose_z", r.pose_z, e.pose_z);
			if (r.pose_yaw !== e.pose_yaw)
				report("pose_yaw", r.pose_yaw, e.pose_yaw);
			if (r.pose_roll !== e.pose_roll)
				report("pose_roll", r.pose_roll, e.pose_roll);
			if (r.playing !== e.playing)
				report("playing", r.playing, e.playing);
			if (r.segment !== e.segment)
				report("segment", r.segment, e.segment);
			if (r.finished !== e.finished)
				report("finished", r.finished, e.finished);
		endtask

		task report_leftovers();
			if (pending_poses.size() != 0)
				report("results never arrived, count", pending_poses.size(), 0);
		endtask
	endclass

	// All inputs of the block carry a known value from time zero on.
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_ready;
	kli_item_t   cmd       = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	kli_result_t res;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAMES;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	pose_predictor poses;
	bit            calm     = 1'b0;	// when set, neither side inserts random idle cycles
	bit            hold_req = 1'b0;	// asks the result side for one long hold-off
	int unsigned   sent     = 0;	// command words sent, not counting the unused mode
	int unsigned   cycles   = 0;

	keyframe_linear_interpolator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Hard stop in case the block hangs somewhere; the limit is several times the slowest
	// legal run (long idle gaps, the long hold-off and a full divide on every word).
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Idle length for either side: mostly none, sometimes a few cycles, rarely a long gap.
	function automatic int idle_len(int long_pct, int short_pct);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < long_pct)
			return $urandom_range(10, 40);
		if (r < short_pct)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	// Channel values: the extremes and small values often enough that both saturation and
	// ordinary interpolation show up, the rest fully random.
	function automatic logic signed [CH_W-1:0] rand_q();
		case ($urandom_range(0, 9))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return '1;
			4, 5: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
			default: return $urandom;
		endcase
	endfunction

	function automatic kli_item_t make_word(logic [1:0] m, logic [SLOT_W-1:0] s,
		logic signed [CH_W-1:0] x, logic signed [CH_W-1:0] y, logic signed [CH_W-1:0] z,
		logic signed [CH_W-1:0] yaw, logic signed [CH_W-1:0] roll);
		kli_item_t w;
		w.mode = m;
		w.frame_slot = s;
		w.key_x = x;
		w.key_y = y;
		w.key_z = z;
		w.key_yaw = yaw;
		w.key_roll = roll;
		return w;
	endfunction

	function automatic kli_item_t random_word(logic [1:0] m);
		return make_word(m, SLOT_W'($urandom_range(0, MAX_KEYFRAMES - 1)),
			rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
	endfunction

	// Offers one command word and returns once it is taken. Valid stays up when the next word
	// follows at once; it only drops for an idle gap.
	task automatic send_word(kli_item_t w);
		int gap;
		cmd <= w;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cmd_ready);
		poses.note_word(w);
		if (w.mode != MODE_UNUSED)
			sent++;
		gap = idle_len(5, 40);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Waits until every predicted result has come back, then lets the block settle so that a
	// register write afterwards finds it idle.
	task automatic drain();
		cmd_valid <= 1'b0;
		while (poses.pending_poses.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		poses.write_reg(idx, val[CFG_DATA_W-1:0]);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// One random phase: new register values while idle, then mostly a well-formed play
	// (a few key writes, a start, ticks to reach the end, up to a cap) with a little noise mixed in.
	// Now and then a phase is pure noise instead. A phase may end while still playing, so the
	// next register write lands in the middle of a play.
	task automatic run_phase();
		int unsigned frames_v;
		int unsigned steps_v;
		int unsigned ticks;
		int          which;
		int          r;
		kli_item_t   w;
		drain();
		calm = ($urandom_range(0, 3) == 0);
		which = $urandom_range(0, 2);
		case ($urandom_range(0, 9))
			0: frames_v = $urandom_range(0, 1);
			1: frames_v = $urandom_range(MAX_KEYFRAMES + 1, 31);
			2: frames_v = MAX_KEYFRAMES;
			default: frames_v = $urandom_range(2, 8);
		endcase
		case ($urandom_range(0, 9))
			0: steps_v = 0;
			1: steps_v = 65535;
			2: steps_v = $urandom_range(5, 40);
			default: steps_v = $urandom_range(1, 4);
		endcase
		if (which != 1)
			set_reg(REG_FRAMES, frames_v);
		if (which != 0)
			set_reg(REG_STEPS, steps_v);
		if ($urandom_range(0, 4) == 0) begin
			repeat (12) send_word(random_word(2'($urandom_range(0, 3))));
		end else begin
			repeat ($urandom_range(0, 3)) send_word(random_word(MODE_WRITE));
			if (poses.running && $urandom_range(0, 1))
				send_word(random_word(MODE_TOGGLE));
			if (!poses.running)
				send_word(random_word(MODE_TOGGLE));
			ticks = poses.frames_used() * (poses.steps_used() + 1) + 2;
			if (ticks > 120)
				ticks = 120;
			repeat (ticks) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					w = random_word(MODE_WRITE);
				else if (r < 5)
					w = random_word(MODE_TOGGLE);
				else if (r < 7)
					w = random_word(MODE_UNUSED);
				else
					w = random_word(MODE_TICK);
				send_word(w);
			end
		end
	endtask

	// Result side: takes results at random, and on request holds off for a long stretch so
	// that the output register fills and the block stops taking command words.
	initial begin : result_side
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (res_valid && res_ready)
				poses.check_result(res);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end else if (stall == 0) begin
				stall = idle_len(2, 20);
			end
			if (stall > 0) begin
				stall--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	initial begin : command_side
		kli_item_t tick_w;
		kli_item_t tog_w;
		poses = new();
		tick_w = make_word(MODE_TICK, '0, '0, '0, '0, '0, '0);
		tog_w = make_word(MODE_TOGGLE, '0, '0, '0, '0, '0, '0);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. With a single frame in use, the unused mode, a start attempt and a
		// tick must all leave the reset state untouched.
		set_reg(REG_FRAMES, 1);
		send_word(make_word(MODE_UNUSED, '1, '1, '1, '1, '1, '1));
		send_word(tog_w);
		send_word(tick_w);
		send_word(make_word(MODE_WRITE, SLOT_W'(0), Q_MAX, Q_MAX, Q_MIN, Q_MIN, '0));
		send_word(make_word(MODE_WRITE, SLOT_W'(1), Q_MAX, Q_MAX, Q_MIN, Q_MIN, '0));
		send_word(make_word(MODE_WRITE, SLOT_W'(2), Q_MAX, Q_MAX, Q_MIN, Q_MIN, '0));

		// Zero steps act as one step. Rewriting slot 1 during play makes the second segment
		// span the full range, so its increments clamp and the pose sums clamp after them;
		// the tick after the clamped step runs off the end and must pulse finished.
		drain();
		set_reg(REG_FRAMES, 3);
		set_reg(REG_STEPS, 0);
		send_word(tog_w);
		send_word(tick_w);
		send_word(make_word(MODE_WRITE, SLOT_W'(1), Q_MIN, Q_MIN, Q_MAX, Q_MAX,
			32'sh0001_0000));
		repeat (4) send_word(tick_w);

		// Stop by toggle in mid-play: pose and segment hold, a tick does nothing, and a new
		// toggle restarts from frame 0. Play is left in the second segment.
		drain();
		set_reg(REG_STEPS, 2);
		send_word(tog_w);
		send_word(tick_w);
		send_word(tog_w);
		send_word(tick_w);
		send_word(tog_w);
		repeat (3) send_word(tick_w);

		// Fewer frames while playing: the current segment is now past the end, so play
		// finishes at the next segment boundary.
		drain();
		set_reg(REG_FRAMES, 2);
		repeat (3) send_word(tick_w);

		// Random part. Every slot gets written first, so no play ever reads an empty slot.
		drain();
		sent = 0;
		for (int s = 0; s < MAX_KEYFRAMES; s++) begin
			tog_w = random_word(MODE_WRITE);
			tog_w.frame_slot = SLOT_W'(s);
			send_word(tog_w);
		end

		// Back pressure: start a play and keep ticking with no gaps while the result side
		// holds off for a long stretch.
		drain();
		set_reg(REG_FRAMES, 4);
		set_reg(REG_STEPS, 3);
		calm = 1'b1;
		if (poses.running)
			send_word(random_word(MODE_TOGGLE));
		send_word(random_word(MODE_TOGGLE));
		hold_req = 1'b1;
		repeat (24) send_word(tick_w);
		calm = 1'b0;

		while (sent < RANDOM_WORDS)
			run_phase();

		calm = 1'b0;
		drain();
		poses.report_leftovers();
		if (poses.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
